/* src/dsc_pkg.sv */
// ----------------------------------------------------------------------------
// dsc_pkg: shared types and helpers for the sensor calibration block
// Holds the key debounce step, the event group from the key controller to the
// channel lanes, and fixed sizes.
// ----------------------------------------------------------------------------
package dsc_pkg;

  // Number of level/sample ports on the block
  localparam int MAX_CH  = 8;
  // Width of the shared debounce delay counter
  localparam int DELAY_W = 8;
  // Reset value of the debounce register
  localparam logic [DELAY_W-1:0] DEBOUNCE_RST = DELAY_W'(2);

  // Result of one key debounce step
  typedef struct packed {
    logic               pending;
    logic [DELAY_W-1:0] delay;
    logic               confirm;
    logic               fire;
  } key_res_t;

  // Per-tick events from the key controller
  typedef struct packed {
    logic beep;
    logic calib;
    logic save;
    logic cap_black;
    logic cap_white;
    logic set_thr;
  } key_evt_t;

  // Lane controls for one request
  typedef struct packed {
    logic cap_black;
    logic cap_white;
    logic set_thr;
  } lane_ctl_t;

  // One debounce step: press, wait, confirm still held, act on release
  function automatic key_res_t key_stage(
    input logic               pending,
    input logic               pressed,
    input logic [DELAY_W-1:0] delay,
    input logic               confirm,
    input logic [DELAY_W-1:0] ticks
  );
    key_res_t r;
    r.pending = pending;
    r.delay   = delay;
    r.confirm = confirm;
    r.fire    = 1'b0;
    if (!pending) begin
      if (pressed) begin
        r.pending = 1'b1;
        r.delay   = ticks;
      end
    end else if (delay == '0) begin
      if (!confirm) begin
        if (pressed) begin
          r.confirm = 1'b1;
        end
      end else if (!pressed) begin
        r.confirm = 1'b0;
        r.pending = 1'b0;
        r.fire    = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

/* src/dsc_key_ctrl.sv */
// ----------------------------------------------------------------------------
// dsc_key_ctrl: key debounce and mode control
// Runs mode, then black and white keys (calibrating only) through one shared
// delay counter and confirm flag each request; reports the tick's events.
// ----------------------------------------------------------------------------
module dsc_key_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [dsc_pkg::DELAY_W-1:0] cfg_wdata,
  input  logic                        accept,
  input  logic                        mode_on,
  input  logic                        black_on,
  input  logic                        white_on,
  output dsc_pkg::key_evt_t           evt
);

  logic [dsc_pkg::DELAY_W-1:0] ticks_r;
  logic [dsc_pkg::DELAY_W-1:0] delay_r, delay_nxt;
  logic                        calib_r, calib_nxt;
  logic                        confirm_r, confirm_nxt;
  logic                        mode_pend_r, mode_pend_nxt;
  logic                        black_pend_r, black_pend_nxt;
  logic                        white_pend_r, white_pend_nxt;

  logic [dsc_pkg::DELAY_W-1:0] delay_dec;
  dsc_pkg::key_res_t           s_mode, s_black, s_white;

  // Step the keys in order: mode, then black, then white
  always_comb begin
    delay_dec = (delay_r != '0) ? delay_r - dsc_pkg::DELAY_W'(1) : delay_r;
    s_mode  = dsc_pkg::key_stage(mode_pend_r, mode_on, delay_dec, confirm_r, ticks_r);
    s_black = dsc_pkg::key_stage(black_pend_r, black_on, s_mode.delay, s_mode.confirm,
                                 ticks_r);
    s_white = dsc_pkg::key_stage(white_pend_r, white_on, s_black.delay, s_black.confirm,
                                 ticks_r);

    evt            = '0;
    mode_pend_nxt  = s_mode.pending;
    black_pend_nxt = black_pend_r;
    white_pend_nxt = white_pend_r;
    calib_nxt      = calib_r;
    if (!calib_r) begin
      // Idle: only the mode key counts
      delay_nxt   = s_mode.delay;
      confirm_nxt = s_mode.confirm;
      if (s_mode.fire) begin
        calib_nxt = 1'b1;
      end
      evt.beep = s_mode.fire;
    end else begin
      delay_nxt      = s_white.delay;
      confirm_nxt    = s_white.confirm;
      black_pend_nxt = s_black.pending;
      white_pend_nxt = s_white.pending;
      if (s_mode.fire) begin
        calib_nxt = 1'b0;
      end
      evt.save      = s_mode.fire;
      evt.set_thr   = s_mode.fire;
      evt.cap_black = s_black.fire;
      evt.cap_white = s_white.fire;
      evt.beep      = s_mode.fire | s_black.fire | s_white.fire;
    end
    evt.calib = calib_nxt;
  end

  // Hold the debounce register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r <= dsc_pkg::DEBOUNCE_RST;
    end else if (cfg_we) begin
      ticks_r <= cfg_wdata;
    end
  end

  // Advance key state on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r      <= '0;
      calib_r      <= 1'b0;
      confirm_r    <= 1'b0;
      mode_pend_r  <= 1'b0;
      black_pend_r <= 1'b0;
      white_pend_r <= 1'b0;
    end else if (accept) begin
      delay_r      <= delay_nxt;
      calib_r      <= calib_nxt;
      confirm_r    <= confirm_nxt;
      mode_pend_r  <= mode_pend_nxt;
      black_pend_r <= black_pend_nxt;
      white_pend_r <= white_pend_nxt;
    end
  end

endmodule

/* src/dsc_lane.sv */
// ----------------------------------------------------------------------------
// dsc_lane: one sensor channel
// Keeps the channel's black, white and threshold values, captures samples and
// forms the midpoint threshold.
// ----------------------------------------------------------------------------
module dsc_lane #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dsc_pkg::lane_ctl_t     ctl,
  input  logic [SAMPLE_BITS-1:0] sample,
  output logic [SAMPLE_BITS-1:0] level_nxt
);

  logic [SAMPLE_BITS-1:0] black_r;
  logic [SAMPLE_BITS-1:0] white_r;
  logic [SAMPLE_BITS-1:0] thr_r;
  logic [SAMPLE_BITS:0]   sum;

  // Midpoint of the stored black and white values
  assign sum       = {1'b0, black_r} + {1'b0, white_r};
  assign level_nxt = ctl.set_thr ? sum[SAMPLE_BITS:1] : thr_r;

  // Capture samples and update the threshold
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      black_r <= '0;
      white_r <= '0;
      thr_r   <= '0;
    end else begin
      if (ctl.cap_black) begin
        black_r <= sample;
      end
      if (ctl.cap_white) begin
        white_r <= sample;
      end
      thr_r <= level_nxt;
    end
  end

endmodule

/* src/debounced_sensor_calibration.sv */
// ----------------------------------------------------------------------------
// debounced_sensor_calibration: key-driven black/white sensor calibration
// Debounces three keys per scan tick and keeps per-channel thresholds.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one request per scan tick with the
//   three key levels and one sample per channel. Output channel (out_valid /
//   out_stall): exactly one result per request, in order, with beep,
//   calibrating, save_request and the thresholds after that tick.
//   Throughput is one request per cycle while in_stall is low: key state
//   and lane stores update in the cycle a request is accepted, and the
//   result goes to the output register.
//   A second slot behind the output register takes one more request while a
//   result is stalled; in_stall rises only when both slots are full and
//   drops once the receiver takes a result.
//   cfg_we writes the debounce register in any cycle; use it while idle.
//   Reset (rst_n low, synchronous) clears key state, stores and thresholds,
//   empties both slots and loads the debounce register with 2.
// ----------------------------------------------------------------------------
module debounced_sensor_calibration #(
  parameter int CHANNELS    = 8,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [dsc_pkg::DELAY_W-1:0] cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_mode_key_level,
  input  logic                        in_black_key_level,
  input  logic                        in_white_key_level,
  input  logic [SAMPLE_BITS-1:0]      in_sample_ch0,
  input  logic [SAMPLE_BITS-1:0]      in_sample_ch1,
  input  logic [SAMPLE_BITS-1:0]      in_sample_ch2,
  input  logic [SAMPLE_BITS-1:0]      in_sample_ch3,
  input  logic [SAMPLE_BITS-1:0]      in_sample_ch4,
  input  logic [SAMPLE_BITS-1:0]      in_sample_ch5,
  input  logic [SAMPLE_BITS-1:0]      in_sample_ch6,
  input  logic [SAMPLE_BITS-1:0]      in_sample_ch7,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_beep,
  output logic                        out_calibrating,
  output logic                        out_save_request,
  output logic [SAMPLE_BITS-1:0]      out_level_ch0,
  output logic [SAMPLE_BITS-1:0]      out_level_ch1,
  output logic [SAMPLE_BITS-1:0]      out_level_ch2,
  output logic [SAMPLE_BITS-1:0]      out_level_ch3,
  output logic [SAMPLE_BITS-1:0]      out_level_ch4,
  output logic [SAMPLE_BITS-1:0]      out_level_ch5,
  output logic [SAMPLE_BITS-1:0]      out_level_ch6,
  output logic [SAMPLE_BITS-1:0]      out_level_ch7
);

  logic                   accept;
  dsc_pkg::key_evt_t      evt;
  dsc_pkg::lane_ctl_t     lane_ctl;
  logic [SAMPLE_BITS-1:0] samples   [dsc_pkg::MAX_CH];
  logic [SAMPLE_BITS-1:0] level_nxt [dsc_pkg::MAX_CH];

  logic                   main_valid_r;
  logic [2:0]             main_flags_r;
  logic [SAMPLE_BITS-1:0] main_level_r [dsc_pkg::MAX_CH];
  logic                   skid_valid_r;
  logic [2:0]             skid_flags_r;
  logic [SAMPLE_BITS-1:0] skid_level_r [dsc_pkg::MAX_CH];
  logic                   main_take;

  assign in_stall = skid_valid_r;
  assign accept   = in_valid & ~skid_valid_r;

  // Key debounce and mode control
  dsc_key_ctrl u_key_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .accept   (accept),
    .mode_on  (in_mode_key_level),
    .black_on (~in_black_key_level),
    .white_on (~in_white_key_level),
    .evt      (evt)
  );

  // Gate lane actions by acceptance
  assign lane_ctl.cap_black = accept & evt.cap_black;
  assign lane_ctl.cap_white = accept & evt.cap_white;
  assign lane_ctl.set_thr   = accept & evt.set_thr;

  assign samples[0] = in_sample_ch0;
  assign samples[1] = in_sample_ch1;
  assign samples[2] = in_sample_ch2;
  assign samples[3] = in_sample_ch3;
  assign samples[4] = in_sample_ch4;
  assign samples[5] = in_sample_ch5;
  assign samples[6] = in_sample_ch6;
  assign samples[7] = in_sample_ch7;

  // One lane per active channel; unused channels read zero
  for (genvar i = 0; i < dsc_pkg::MAX_CH; i++) begin : g_lane
    if (i < CHANNELS) begin : g_on
      dsc_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (lane_ctl),
        .sample   (samples[i]),
        .level_nxt(level_nxt[i])
      );
    end else begin : g_off
      assign level_nxt[i] = '0;
    end
  end

  // Output register with one skid slot
  assign main_take = ~main_valid_r | ~out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (main_take) begin
      if (skid_valid_r) begin
        main_valid_r <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        main_valid_r <= accept;
      end
    end else if (accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Merge lane levels and key flags into the result slots
  always_ff @(posedge clk) begin
    if (main_take) begin
      if (skid_valid_r) begin
        main_flags_r <= skid_flags_r;
        main_level_r <= skid_level_r;
      end else if (accept) begin
        main_flags_r <= {evt.beep, evt.calib, evt.save};
        main_level_r <= level_nxt;
      end
    end else if (accept) begin
      skid_flags_r <= {evt.beep, evt.calib, evt.save};
      skid_level_r <= level_nxt;
    end
  end

  assign out_valid        = main_valid_r;
  assign out_beep         = main_flags_r[2];
  assign out_calibrating  = main_flags_r[1];
  assign out_save_request = main_flags_r[0];
  assign out_level_ch0    = main_level_r[0];
  assign out_level_ch1    = main_level_r[1];
  assign out_level_ch2    = main_level_r[2];
  assign out_level_ch3    = main_level_r[3];
  assign out_level_ch4    = main_level_r[4];
  assign out_level_ch5    = main_level_r[5];
  assign out_level_ch6    = main_level_r[6];
  assign out_level_ch7    = main_level_r[7];

endmodule

/* src/dsc_checker.sv */
// ----------------------------------------------------------------------------
// dsc_checker: port-level checks for the sensor calibration block
// Watches the top-level ports and flags slips in buffering and mode results.
// ----------------------------------------------------------------------------
module dsc_checker #(
  parameter int SAMPLE_BITS = 12
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic                   out_beep,
  input logic                   out_calibrating,
  input logic                   out_save_request,
  input logic [SAMPLE_BITS-1:0] out_level_ch0
);

  // Backpressure only when a result is already waiting
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("in_stall high with no result waiting");

  // Save ends calibration
  a_save_leaves_calib: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_save_request) |-> !out_calibrating)
    else $error("save_request while still calibrating");

  // Save is a completed key action
  a_save_beeps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_save_request) |-> out_beep)
    else $error("save_request without beep");

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid after reset");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_level_ch0)))
    else $error("stalled result changed");

endmodule

bind debounced_sensor_calibration dsc_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_dsc_checker (.*);
